FILE: rtl/mtg_pkg.sv
`timescale 1ns / 1ps
// mtg_pkg: shared types and constants of the metronome tone generator.
// Holds the quarter-wave sine table, built at elaboration. No dependencies.
package mtg_pkg;

	// quarter-wave table, SINE_TABLE_DEPTH+1 entries covering 0..pi/2
	localparam int SINE_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// config register indexes
	localparam logic [2:0] REG_BEAT_PERIOD = 3'd0;
	localparam logic [2:0] REG_TONE        = 3'd1;
	localparam logic [2:0] REG_ATTACK      = 3'd2;
	localparam logic [2:0] REG_DECAY       = 3'd3;
	localparam logic [2:0] REG_PHASE_STEP  = 3'd4;
	localparam logic [2:0] REG_PEAK        = 3'd5;
	localparam logic [2:0] REG_FOLLOW      = 3'd6;

	// shared divider geometry
	localparam int DIV_NUM_W  = 40;
	localparam int DIV_DEN_W  = 24;
	localparam int DIV_STEP_W = 6;

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} mtg_div_ctl_t;

	typedef logic [14:0] mtg_sine_tab_t [0:SINE_TABLE_DEPTH];

	// Q30 Horner series for sin, rounded to Q0.15
	function automatic mtg_sine_tab_t build_sine_tab();
		mtg_sine_tab_t tab;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			x  = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			t  = Q30_ONE - (((x2 * t) >> 30) / 110);
			t  = Q30_ONE - (((x2 * t) >> 30) / 72);
			t  = Q30_ONE - (((x2 * t) >> 30) / 42);
			t  = Q30_ONE - (((x2 * t) >> 30) / 20);
			t  = Q30_ONE - (((x2 * t) >> 30) / 6);
			s  = (x * t) >> 30;
			tab[k] = 15'((s * 64'd32767 + (Q30_ONE >> 1)) >> 30);
		end
		return tab;
	endfunction

	localparam mtg_sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: rtl/mtg_divider.sv
`timescale 1ns / 1ps
// mtg_divider: restoring divider, one quotient bit per cycle.
// Uses mtg_pkg for widths and the control struct.
module mtg_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mtg_pkg::mtg_div_ctl_t           ctl,
	input  logic [mtg_pkg::DIV_NUM_W-1:0]   numer,   // left aligned
	input  logic [mtg_pkg::DIV_DEN_W-1:0]   divisor,
	output logic                            done,
	output logic [mtg_pkg::DIV_NUM_W-1:0]   quot,    // low 'steps' bits
	output logic [mtg_pkg::DIV_DEN_W-1:0]   rem
);

	logic                            busy_q;
	logic                            done_q;
	logic [mtg_pkg::DIV_STEP_W-1:0]  cnt_q;
	logic [mtg_pkg::DIV_NUM_W-1:0]   num_q;
	logic [mtg_pkg::DIV_DEN_W-1:0]   den_q;
	logic [mtg_pkg::DIV_DEN_W-1:0]   rem_q;
	logic [mtg_pkg::DIV_DEN_W+1:0]   trial;
	logic                            ge;

	// partial remainder with next numerator bit, minus divisor
	assign trial = {1'b0, rem_q, num_q[mtg_pkg::DIV_NUM_W-1]} - {2'b00, den_q};
	assign ge    = ~trial[mtg_pkg::DIV_DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mtg_pkg::DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= numer;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[mtg_pkg::DIV_NUM_W-2:0], ge};
			if (ge) begin
				rem_q <= trial[mtg_pkg::DIV_DEN_W-1:0];
			end else begin
				rem_q <= {rem_q[mtg_pkg::DIV_DEN_W-2:0], num_q[mtg_pkg::DIV_NUM_W-1]};
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/metronome_tone_generator_top.sv
`timescale 1ns / 1ps
// Metronome click tone generator: one tick word in, one Q0.15 sample word out.
// A stopped tick skips to the output; other ticks step the position, and one in the tone
// runs phase, lookup and scale, plus a 39-step envelope divide on a ramp; a resync adds a
// 32-step mod divide first. A tick is taken only after the last word is loaded for output.
// Reset (arst_n low, async) loads the register defaults and zeroes the position.
// Uses mtg_pkg and mtg_divider.
module metronome_tone_generator_top #(
	parameter int POSITION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] frame_position
	input  logic [1:0]  s_tuser,   // [0] rolling, [1] resync
	// sample words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample, signed Q0.15
	output logic [0:0]  m_tuser,   // [0] beat_start
	// config writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MOD_GO   = 4'd1;
	localparam logic [3:0] S_MOD_WAIT = 4'd2;
	localparam logic [3:0] S_POS      = 4'd3;
	localparam logic [3:0] S_PHASE    = 4'd4;
	localparam logic [3:0] S_LOOKUP   = 4'd5;
	localparam logic [3:0] S_ENV_SEL  = 4'd6;
	localparam logic [3:0] S_ENV_MUL  = 4'd7;
	localparam logic [3:0] S_ENV_GO   = 4'd8;
	localparam logic [3:0] S_ENV_WAIT = 4'd9;
	localparam logic [3:0] S_SCALE    = 4'd10;
	localparam logic [3:0] S_FINISH   = 4'd11;
	localparam logic [3:0] S_DONE     = 4'd12;

	// ---------------- config registers ----------------
	logic [23:0] beat_period_q;
	logic [23:0] tone_q;
	logic [23:0] attack_q;
	logic [23:0] decay_q;
	logic [15:0] phase_step_q;
	logic [14:0] peak_q;
	logic        follow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_period_q <= 24'd24000;
			tone_q        <= 24'd4800;
			attack_q      <= 24'd48;
			decay_q       <= 24'd480;
			phase_step_q  <= 16'd1202;
			peak_q        <= 15'd16384;
			follow_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mtg_pkg::REG_BEAT_PERIOD: beat_period_q <= cfg_data;
				mtg_pkg::REG_TONE:        tone_q        <= cfg_data;
				mtg_pkg::REG_ATTACK:      attack_q      <= cfg_data;
				mtg_pkg::REG_DECAY:       decay_q       <= cfg_data;
				mtg_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_data[15:0];
				mtg_pkg::REG_PEAK:        peak_q        <= cfg_data[14:0];
				mtg_pkg::REG_FOLLOW:      follow_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a period below 2 behaves as 2
	logic [23:0] period_eff;
	assign period_eff = (beat_period_q < 24'd2) ? 24'd2 : beat_period_q;

	// ---------------- working state ----------------
	logic [3:0]               state_q;
	logic [POSITION_BITS-1:0] pos_q;      // beat position, survives between words
	logic [31:0]              frame_q;
	logic [23:0]              p_q;        // clamped position of this sample
	logic [23:0]              env_x_q;    // envelope ramp numerator term
	logic [23:0]              env_div_q;  // envelope ramp length
	logic [14:0]              env_q;
	logic [14:0]              mag_q;
	logic                     neg_q;
	logic [15:0]              samp_q;
	logic                     bs_q;
	logic [39:0]              prod_q;

	// output register
	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic        out_bs_q;

	// ---------------- shared multiplier, registered ----------------
	logic [23:0] mul_a;
	logic [15:0] mul_b;

	always_comb begin
		case (state_q)
			S_PHASE: begin
				mul_a = 24'(p_q[15:0]);
				mul_b = phase_step_q;
			end
			S_ENV_MUL: begin
				mul_a = env_x_q;
				mul_b = 16'(peak_q);
			end
			S_SCALE: begin
				mul_a = 24'(mag_q);
				mul_b = 16'(env_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 40'(mul_a) * 40'(mul_b);
	end

	// ---------------- shared divider ----------------
	// mod: frame / period, 32 steps, remainder used
	// envelope: peak*x / len, 39 steps, quotient used (fits 15 bits)
	mtg_pkg::mtg_div_ctl_t div_ctl;
	logic [39:0]           div_num;
	logic [23:0]           div_den;
	logic                  div_done;
	logic [39:0]           div_quot;
	logic [23:0]           div_rem;

	always_comb begin
		div_ctl.start = (state_q == S_MOD_GO) || (state_q == S_ENV_GO);
		if (state_q == S_MOD_GO) begin
			div_ctl.steps = mtg_pkg::DIV_STEP_W'(32);
			div_num       = {frame_q, 8'd0};
			div_den       = period_eff;
		end else begin
			div_ctl.steps = mtg_pkg::DIV_STEP_W'(39);
			div_num       = {prod_q[38:0], 1'b0};
			div_den       = env_div_q;
		end
	end

	mtg_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.numer   (div_num),
		.divisor (div_den),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// ---------------- position step ----------------
	logic [23:0] p_clamp;
	logic [24:0] p_inc;
	logic [POSITION_BITS-1:0] pos_next;

	always_comb begin
		// a position at or past the period (period was lowered) acts as zero
		p_clamp  = (33'(pos_q) >= 33'(period_eff)) ? 24'd0 : 24'(pos_q);
		p_inc    = 25'(p_clamp) + 25'd1;
		pos_next = (p_inc >= 25'(period_eff)) ? '0 : POSITION_BITS'(p_inc);
	end

	// ---------------- quarter-wave lookup ----------------
	logic [1:0]                  quad;
	logic [14:0]                 fold;
	logic [27:0]                 idx_wide;
	logic [mtg_pkg::IDX_W-1:0]   tab_idx;

	always_comb begin
		quad     = prod_q[15:14];
		// odd quadrants run the table backwards
		fold     = quad[0] ? (15'd16384 - {1'b0, prod_q[13:0]}) : {1'b0, prod_q[13:0]};
		idx_wide = (28'(fold) * 28'(mtg_pkg::SINE_TABLE_DEPTH)) >> 14;
		tab_idx  = mtg_pkg::IDX_W'(idx_wide);
	end

	// ---------------- envelope select ----------------
	logic [23:0] left;
	assign left = tone_q - p_q;

	// ---------------- sequencer ----------------
	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (follow_q && !s_tuser[0]) begin
							// stopped transport: silence, position held
							state_q <= S_DONE;
						end else if (follow_q && s_tuser[1]) begin
							state_q <= S_MOD_GO;
						end else begin
							state_q <= S_POS;
						end
					end
				end
				S_MOD_GO:   state_q <= S_MOD_WAIT;
				S_MOD_WAIT: begin
					if (div_done) begin
						pos_q   <= POSITION_BITS'(div_rem);
						state_q <= S_POS;
					end
				end
				S_POS: begin
					pos_q   <= pos_next;
					state_q <= (p_clamp < tone_q) ? S_PHASE : S_DONE;
				end
				S_PHASE:   state_q <= S_LOOKUP;
				S_LOOKUP:  state_q <= S_ENV_SEL;
				S_ENV_SEL: begin
					if ((decay_q != 24'd0 && left <= decay_q) || (p_q < attack_q)) begin
						state_q <= S_ENV_MUL;
					end else begin
						state_q <= S_SCALE;
					end
				end
				S_ENV_MUL:  state_q <= S_ENV_GO;
				S_ENV_GO:   state_q <= S_ENV_WAIT;
				S_ENV_WAIT: begin
					if (div_done) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE:  state_q <= S_FINISH;
				S_FINISH: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				frame_q <= s_tdata;
				samp_q  <= '0;
				bs_q    <= 1'b0;
			end
			S_POS: begin
				p_q    <= p_clamp;
				bs_q   <= (p_clamp == 24'd0);
				samp_q <= '0;
			end
			S_LOOKUP: begin
				mag_q <= mtg_pkg::SINE_TAB[tab_idx];
				neg_q <= quad[1];
			end
			S_ENV_SEL: begin
				// decay wins where it overlaps the attack
				if (decay_q != 24'd0 && left <= decay_q) begin
					env_x_q   <= left;
					env_div_q <= decay_q;
				end else begin
					env_x_q   <= p_q;
					env_div_q <= attack_q;
				end
				env_q <= peak_q;
			end
			S_ENV_WAIT: begin
				if (div_done) begin
					env_q <= div_quot[14:0];
				end
			end
			S_FINISH: begin
				samp_q <= neg_q ? (16'd0 - 16'(prod_q[29:15])) : 16'(prod_q[29:15]);
			end
			default: ;
		endcase
	end

	// output register: holds a finished word while the next tick is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= samp_q;
			out_bs_q     <= bs_q;
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_sample_q;
	assign m_tuser[0] = out_bs_q;

endmodule

FILE: rtl/mtg_checker.sv
`timescale 1ns / 1ps
// mtg_checker: port-level checks of the metronome tone generator, bound to the top.
// Depends on metronome_tone_generator_top port names.
module mtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// one tick at a time: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// beat start is phase zero, so the sample is zero
	a_beat_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
		else $error("nonzero sample at beat start");

	// magnitude never reaches full scale
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 16'h8000)
		else $error("sample at negative full scale");

endmodule

bind metronome_tone_generator_top mtg_checker u_mtg_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for the click tone generator (metronome_tone_generator_top).
// Drives tick words, predicts each sample word with an in-bench model and checks them.
// Depends on mtg_pkg (register indexes, table depth) and the RTL top level.
module tb;

	localparam int POS_BITS = 24;
	localparam int RANDOM_TICKS = 1200;
	localparam int SETTLE_CYCLES = 8;     // idle margin before a register write
	localparam int TAIL_CYCLES = 120;     // watch for stray words after the last one
	localparam logic [2:0] REG_SPARE = 3'd7;  // decoded as no register

	localparam longint unsigned UNIT_Q30 = 64'd1073741824;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam int unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};

	typedef struct packed {
		logic signed [15:0] sample;
		logic               beat_start;
	} sample_word_t;

	// clock, reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// tick words in
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] frame_position
	logic [1:0]  s_tuser = '0;   // [0] rolling, [1] resync

	// sample words out
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] sample, signed Q0.15
	logic [0:0]  m_tuser;        // [0] beat_start

	// register writes
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	metronome_tone_generator_top #(
		.POSITION_BITS(POS_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Mirror of the register file and beat position; initial values are the reset state.
	logic [23:0]         period_reg = 24'd24000;
	logic [23:0]         tone_reg = 24'd4800;
	logic [23:0]         attack_reg = 24'd48;
	logic [23:0]         decay_reg = 24'd480;
	logic [15:0]         step_reg = 16'd1202;
	logic [14:0]         peak_reg = 15'd16384;
	logic                follow_reg = 1'b0;
	logic [POS_BITS-1:0] position = '0;

	logic [14:0] quarter_sine [0:mtg_pkg::SINE_TABLE_DEPTH];
	sample_word_t pending_samples [$];

	bit gaps_on = 1'b1;      // sender idles between words
	bit stalls_on = 1'b1;    // receiver drops tready between words

	int mismatch_count = 0;
	int ticks_sent = 0;
	int settings_count = 0;
	int stopped_ticks = 0;
	int resync_ticks = 0;
	int beat_starts_seen = 0;
	int audible_words = 0;

	// Quarter-wave sine, Q30 Horner series, rounded to 15 bits.
	initial begin : build_quarter_sine
		longint unsigned x, x2, t, s;
		for (int k = 0; k <= mtg_pkg::SINE_TABLE_DEPTH; k++) begin
			x  = (longint'(k) * QUARTER_TURN_Q30) / mtg_pkg::SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			t  = UNIT_Q30;
			for (int i = 0; i < 5; i++)
				t = UNIT_Q30 - (((x2 * t) >> 30) / HORNER_DIV[i]);
			s  = (x * t) >> 30;
			quarter_sine[k] = 15'((s * 64'd32767 + (UNIT_Q30 >> 1)) >> 30);
		end
	end

	// Full-turn sine from the quarter table: odd quadrants mirror, upper half negates.
	function automatic int sine_lookup(logic [15:0] phase);
		logic [1:0]  quad;
		int unsigned frac;
		int unsigned idx;
		int          mag;
		quad = phase[15:14];
		frac = 32'(phase[13:0]);
		if (quad[0])
			frac = 16384 - frac;
		idx = (frac * mtg_pkg::SINE_TABLE_DEPTH) >> 14;
		if (idx > mtg_pkg::SINE_TABLE_DEPTH)
			idx = mtg_pkg::SINE_TABLE_DEPTH;
		mag = 32'(quarter_sine[idx]);
		return quad[1] ? -mag : mag;
	endfunction

	// Attack ramp, hold, decay ramp; decay takes priority where the two overlap.
	function automatic longint unsigned envelope_at(longint unsigned p);
		longint unsigned left;
		left = 64'(tone_reg) - p;
		if (decay_reg != 0 && left <= 64'(decay_reg))
			return (64'(peak_reg) * left) / 64'(decay_reg);
		if (p < 64'(attack_reg))
			return (64'(peak_reg) * p) / 64'(attack_reg);
		return 64'(peak_reg);
	endfunction

	// Expected word for one tick; advances the mirrored beat position.
	function automatic sample_word_t predict_click_sample(logic rolling, logic resync,
			logic [31:0] frame);
		longint unsigned period, p, phase, mag, scaled;
		int              wave;
		int              level;
		sample_word_t    word;
		period = (period_reg < 24'd2) ? 64'd2 : 64'(period_reg);
		word   = '0;
		// stopped transport: silence, position frozen, resync ignored
		if (follow_reg && !rolling)
			return word;
		if (follow_reg && resync)
			position = POS_BITS'(64'(frame) % period);
		p = 64'(position);
		if (p >= period)
			p = 64'd0;   // period was lowered under the running position
		level = 0;
		if (p < 64'(tone_reg)) begin
			phase  = (64'(step_reg) * p) & 64'hFFFF;
			wave   = sine_lookup(phase[15:0]);
			mag    = 64'((wave < 0) ? -wave : wave);
			scaled = (envelope_at(p) * mag) >> 15;
			level  = (wave < 0) ? -int'(scaled) : int'(scaled);
		end
		word.sample     = level[15:0];
		word.beat_start = (p == 64'd0);
		if (p + 64'd1 >= period)
			position = '0;
		else
			position = POS_BITS'(p + 64'd1);
		return word;
	endfunction

	// One register write; the mirror keeps only the register's own bits.
	task automatic write_reg(logic [2:0] index, logic [23:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (index)
			mtg_pkg::REG_BEAT_PERIOD: period_reg = value;
			mtg_pkg::REG_TONE:        tone_reg = value;
			mtg_pkg::REG_ATTACK:      attack_reg = value;
			mtg_pkg::REG_DECAY:       decay_reg = value;
			mtg_pkg::REG_PHASE_STEP:  step_reg = value[15:0];
			mtg_pkg::REG_PEAK:        peak_reg = value[14:0];
			mtg_pkg::REG_FOLLOW:      follow_reg = value[0];
			default: ;
		endcase
	endtask

	// Half the time, sets junk above a narrow register's width.
	function automatic logic [23:0] pad_upper(logic [23:0] value, int width);
		logic [23:0] junk;
		junk = 24'($urandom);
		if ($urandom_range(0, 1))
			return value;
		return value | (junk & ~((24'd1 << width) - 24'd1));
	endfunction

	// Send one tick word, then queue its expected sample word once accepted.
	task automatic send_tick(logic rolling, logic resync, logic [31:0] frame);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= frame;
		s_tuser  <= {resync, rolling};
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		if (follow_reg && !rolling)
			stopped_ticks++;
		else if (follow_reg && resync)
			resync_ticks++;
		pending_samples.push_back(predict_click_sample(rolling, resync, frame));
		ticks_sent++;
	endtask

	// Stop sending and let every outstanding word come back.
	task automatic drain_samples();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reset defaults; transport off, so rolling and resync must be ignored.
	task automatic test_reset_defaults();
		for (int i = 0; i < 5; i++)
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
	endtask

	// Period 0 behaves as 2; a tone longer than the beat is cut at the wrap.
	task automatic test_short_period();
		drain_samples();
		write_reg(mtg_pkg::REG_BEAT_PERIOD, 24'd0);
		write_reg(mtg_pkg::REG_TONE, 24'd3);
		write_reg(mtg_pkg::REG_ATTACK, 24'd0);
		write_reg(mtg_pkg::REG_DECAY, 24'd0);
		write_reg(mtg_pkg::REG_PHASE_STEP, 24'h004000);
		write_reg(mtg_pkg::REG_PEAK, 24'h007FFF);
		write_reg(mtg_pkg::REG_FOLLOW, 24'd0);
		settings_count++;
		for (int i = 0; i < 4; i++)
			send_tick(1'b0, 1'b0, 32'h0);
	endtask

	// Transport gating and resync, with attack and decay overlapping.
	task automatic test_transport();
		drain_samples();
		write_reg(mtg_pkg::REG_BEAT_PERIOD, 24'd16);
		write_reg(mtg_pkg::REG_TONE, 24'd12);
		write_reg(mtg_pkg::REG_ATTACK, 24'd8);
		write_reg(mtg_pkg::REG_DECAY, 24'd6);
		write_reg(mtg_pkg::REG_PHASE_STEP, 24'h001000);
		write_reg(mtg_pkg::REG_PEAK, 24'h007FFF);
		write_reg(mtg_pkg::REG_FOLLOW, 24'd1);
		settings_count++;
		send_tick(1'b0, 1'b1, 32'h0000_0009);   // stopped: resync ignored
		send_tick(1'b1, 1'b0, 32'h0);
		send_tick(1'b1, 1'b0, 32'h0);
		send_tick(1'b1, 1'b0, 32'h0);
		send_tick(1'b1, 1'b1, 32'hFFFF_FFFF);   // lands past the tone
		send_tick(1'b1, 1'b0, 32'h0);            // wraps to beat start
		send_tick(1'b1, 1'b1, 32'h0000_0007);
		send_tick(1'b1, 1'b0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0);
	endtask

	// Lowering the period under the running position restarts the beat.
	task automatic test_stale_position();
		drain_samples();
		write_reg(mtg_pkg::REG_BEAT_PERIOD, 24'd1000);
		write_reg(mtg_pkg::REG_TONE, 24'd2000);
		settings_count++;
		send_tick(1'b1, 1'b1, 32'd900);
		send_tick(1'b1, 1'b0, 32'h0);
		drain_samples();
		write_reg(mtg_pkg::REG_BEAT_PERIOD, 24'd100);
		settings_count++;
		send_tick(1'b1, 1'b0, 32'h0);
		send_tick(1'b1, 1'b0, 32'h0);
	endtask

	// Random register settings, each followed by a burst of ticks.
	task automatic test_random_settings();
		int unsigned period, span, tone, attack, decay, step, peak, dice, offset;
		int          first, burst;
		logic        rolling, resync;
		logic [31:0] frame;
		first = ticks_sent;
		while (ticks_sent - first < RANDOM_TICKS) begin
			drain_samples();
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);

			dice = $urandom_range(0, 19);
			if (dice < 2)       period = $urandom_range(0, 3);
			else if (dice < 12) period = $urandom_range(2, 64);
			else if (dice < 16) period = $urandom_range(65, 5000);
			else if (dice < 18) period = 32'h00FF_FFFF;
			else                period = $urandom_range(5001, 32'h00FF_FFFF);
			span = (period < 2) ? 2 : period;

			dice = $urandom_range(0, 9);
			if (dice == 0)      tone = $urandom_range(0, 1);
			else if (dice == 1) tone = 32'h00FF_FFFE;
			else if (dice == 2) tone = span + $urandom_range(0, 3);
			else                tone = $urandom_range(1, span - 1);

			dice = $urandom_range(0, 9);
			if (dice == 0)      attack = 0;
			else if (dice == 1) attack = 32'h00FF_FFFE;
			else                attack = $urandom_range(0, tone + 2);

			dice = $urandom_range(0, 9);
			if (dice == 0)      decay = 0;
			else if (dice == 1) decay = 32'h00FF_FFFE;
			else                decay = $urandom_range(0, tone + 2);

			dice = $urandom_range(0, 9);
			if (dice == 0)      step = 0;
			else if (dice == 1) step = 32'h0000_FFFF;
			else if (dice == 2) step = 32'h0000_4000 * $urandom_range(0, 3);
			else                step = $urandom_range(0, 32'h0000_FFFF);

			dice = $urandom_range(0, 9);
			if (dice == 0)      peak = 0;
			else if (dice == 1) peak = 32'h0000_7FFF;
			else                peak = $urandom_range(0, 32'h0000_7FFF);

			// occasionally keep an old value, so stale combinations also occur
			if ($urandom_range(0, 7) != 0) write_reg(mtg_pkg::REG_BEAT_PERIOD, 24'(period));
			if ($urandom_range(0, 7) != 0) write_reg(mtg_pkg::REG_TONE, 24'(tone));
			if ($urandom_range(0, 7) != 0) write_reg(mtg_pkg::REG_ATTACK, 24'(attack));
			if ($urandom_range(0, 7) != 0) write_reg(mtg_pkg::REG_DECAY, 24'(decay));
			if ($urandom_range(0, 7) != 0)
				write_reg(mtg_pkg::REG_PHASE_STEP, pad_upper(24'(step), 16));
			if ($urandom_range(0, 7) != 0)
				write_reg(mtg_pkg::REG_PEAK, pad_upper(24'(peak), 15));
			if ($urandom_range(0, 3) != 0)
				write_reg(mtg_pkg::REG_FOLLOW, pad_upper(24'($urandom_range(0, 1)), 1));
			if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, 24'($urandom));
			settings_count++;

			span  = (period_reg < 24'd2) ? 32'd2 : 32'(period_reg);
			burst = $urandom_range(10, 60);
			for (int i = 0; i < burst; i++) begin
				// mostly a rolling transport with occasional resyncs, some stops
				dice    = $urandom_range(0, 19);
				rolling = (dice != 0);
				resync  = (dice == 1) || (dice >= 18);
				if (dice == 0)
					resync = 1'($urandom_range(0, 1));
				if (!follow_reg && $urandom_range(0, 1))
					{resync, rolling} = 2'($urandom);
				frame = $urandom;
				if (resync && $urandom_range(0, 1)) begin
					// aim the resync at the envelope corners
					case ($urandom_range(0, 2))
						0:       offset = 32'(tone_reg) - $urandom_range(0, 32'(decay_reg) + 1);
						1:       offset = 32'(attack_reg) + $urandom_range(0, 2) - 1;
						default: offset = $urandom_range(0, span - 1);
					endcase
					frame = 32'(longint'(span) * $urandom_range(0, 255) + offset);
				end
				send_tick(rolling, resync, frame);
			end
		end
		drain_samples();
	endtask

	// Receiver: random tready stalls, compares each accepted word with the oldest expectation.
	initial begin : sample_checker
		int           stall;
		sample_word_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = stalls_on ? $urandom_range(0, 4) : 0;
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1) @(posedge clk);
			if (pending_samples.size() == 0) begin
				$error("unexpected sample word: sample %0d beat_start %b",
					$signed(m_tdata), m_tuser[0]);
				mismatch_count++;
			end else begin
				want = pending_samples.pop_front();
				if (m_tdata !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample, $signed(m_tdata));
					mismatch_count++;
				end
				if (m_tuser[0] !== want.beat_start) begin
					$error("beat_start: expected %b, got %b", want.beat_start, m_tuser[0]);
					mismatch_count++;
				end
				if (want.beat_start)
					beat_starts_seen++;
				if (want.sample != 0)
					audible_words++;
			end
		end
	end

	// Main sequence.
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_short_period();
		test_transport();
		test_stale_position();
		test_random_settings();

		// all sent; wait for the last words, then watch for strays
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d ticks over %0d register settings (%0d stopped, %0d resyncs).",
			ticks_sent, settings_count, stopped_ticks, resync_ticks);
		$display("Summary: %0d beat starts and %0d audible words checked.",
			beat_starts_seen, audible_words);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog: time limit, several times the slowest legal run.
	initial begin
		#20_000_000;
		$display("Timeout with %0d words outstanding.", pending_samples.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
